@@ rtl/interrupt_pending_mask_controller_defines.svh @@
// ----------------------------------------------------------------------------
// Interrupt pending/mask controller assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_PENDING_MASK_CONTROLLER_DEFINES_SVH
`define INTERRUPT_PENDING_MASK_CONTROLLER_DEFINES_SVH

// Overlapping implication: the consequent is checked from the same edge.
`define IPMC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

// Next-cycle implication: the consequent is checked on the edge after the antecedent.
`define IPMC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ipmc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipmc_pkg
// Types and register offsets of the interrupt pending/mask controller.
// ----------------------------------------------------------------------------
package ipmc_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_REQUEST = 2'd2,
        CMD_ACK     = 2'd3
    } cmd_t;

    localparam logic [5:0] ADDR_ENABLE_A  = 6'h07;
    localparam logic [5:0] ADDR_ENABLE_B  = 6'h09;
    localparam logic [5:0] ADDR_PENDING_A = 6'h0b;
    localparam logic [5:0] ADDR_PENDING_B = 6'h0d;
    localparam logic [5:0] ADDR_INSERV_A  = 6'h0f;
    localparam logic [5:0] ADDR_INSERV_B  = 6'h11;
    localparam logic [5:0] ADDR_MASK_A    = 6'h13;
    localparam logic [5:0] ADDR_MASK_B    = 6'h15;
    localparam logic [5:0] ADDR_VECTOR    = 6'h17;

    // Bit of the vector register that selects software end-of-interrupt.
    localparam int unsigned VEC_SEOI_BIT = 3;

    typedef struct packed {
        cmd_t       cmd;
        logic [5:0] reg_addr;
        logic [7:0] write_data;
        logic [3:0] channel;
    } req_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] irq_raise;
    } rsp_t;

endpackage

@@ rtl/ipmc_stream_if.sv @@
// ----------------------------------------------------------------------------
// ipmc_stream_if
// Valid/ready channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
interface ipmc_stream_if #(
    parameter type payload_t = logic [7:0]
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/ipmc_regs.sv @@
// ----------------------------------------------------------------------------
// ipmc_regs
// Register file and update logic: applies one item per fire strobe and
// produces its result combinationally from the state before the update.
// ----------------------------------------------------------------------------
module ipmc_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  ipmc_pkg::req_t item,
    output ipmc_pkg::rsp_t result
);
    import ipmc_pkg::*;

    logic [15:0] enable_reg, enable_next;
    logic [15:0] pending_reg, pending_next;
    logic [15:0] inserv_reg, inserv_next;
    logic [15:0] mask_reg, mask_next;
    logic [7:0]  vector_reg, vector_next;
    logic        seoi_reg, seoi_next;

    logic        high;
    logic [15:0] lanes;
    logic [15:0] and_byte;
    logic [15:0] chan_bit;
    logic [15:0] ready_bits;
    logic [15:0] mask_rise;

    always_comb
    begin
        high     = (item.reg_addr == ADDR_ENABLE_A) || (item.reg_addr == ADDR_PENDING_A)
                || (item.reg_addr == ADDR_INSERV_A) || (item.reg_addr == ADDR_MASK_A);
        lanes    = high ? 16'hff00 : 16'h00ff;
        and_byte = high ? {item.write_data, 8'hff} : {8'hff, item.write_data};
        chan_bit = 16'd1 << item.channel;

        enable_next  = enable_reg;
        pending_next = pending_reg;
        inserv_next  = inserv_reg;
        mask_next    = mask_reg;
        vector_next  = vector_reg;
        seoi_next    = seoi_reg;
        ready_bits   = '0;
        mask_rise    = '0;
        result       = '0;

        case (item.cmd)
            CMD_WRITE:
            begin
                case (item.reg_addr)
                    ADDR_ENABLE_A, ADDR_ENABLE_B:
                    begin
                        enable_next  = (enable_reg & ~lanes) | (and_byte & lanes);
                        pending_next = pending_reg & (enable_next | ~lanes);
                    end
                    ADDR_PENDING_A, ADDR_PENDING_B:
                    begin
                        pending_next = pending_reg & and_byte;
                    end
                    ADDR_INSERV_A, ADDR_INSERV_B:
                    begin
                        inserv_next = inserv_reg & and_byte;
                        ready_bits  = enable_reg & mask_reg & pending_reg & ~inserv_next;
                        if ((ready_bits & lanes) != '0)
                        begin
                            result.irq_raise = ready_bits;
                        end
                    end
                    ADDR_MASK_A, ADDR_MASK_B:
                    begin
                        mask_next = (mask_reg & ~lanes) | (and_byte & lanes);
                        mask_rise = mask_next & ~mask_reg;
                        if ((mask_rise & enable_reg & pending_reg & ~inserv_reg & lanes) != '0)
                        begin
                            result.irq_raise = mask_rise & pending_reg;
                        end
                    end
                    ADDR_VECTOR:
                    begin
                        vector_next = item.write_data;
                        seoi_next   = item.write_data[VEC_SEOI_BIT];
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_READ:
            begin
                case (item.reg_addr)
                    ADDR_ENABLE_A:  result.read_data = enable_reg[15:8];
                    ADDR_ENABLE_B:  result.read_data = enable_reg[7:0];
                    ADDR_PENDING_A: result.read_data = pending_reg[15:8];
                    ADDR_PENDING_B: result.read_data = pending_reg[7:0];
                    ADDR_INSERV_A:  result.read_data = inserv_reg[15:8];
                    ADDR_INSERV_B:  result.read_data = inserv_reg[7:0];
                    ADDR_MASK_A:    result.read_data = mask_reg[15:8];
                    ADDR_MASK_B:    result.read_data = mask_reg[7:0];
                    ADDR_VECTOR:    result.read_data = vector_reg;
                    default:        result.read_data = '0;
                endcase
            end
            CMD_REQUEST:
            begin
                if (((enable_reg & chan_bit) != '0) && ((pending_reg & chan_bit) == '0))
                begin
                    pending_next = pending_reg | chan_bit;
                    if (((mask_reg & chan_bit) != '0)
                        && !(seoi_reg && ((inserv_reg & chan_bit) != '0)))
                    begin
                        result.irq_raise = chan_bit;
                    end
                end
            end
            CMD_ACK:
            begin
                pending_next = pending_reg & ~chan_bit;
                if (seoi_reg)
                begin
                    inserv_next = inserv_reg | chan_bit;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= '0;
            pending_reg <= '0;
            inserv_reg  <= '0;
            mask_reg    <= '0;
            vector_reg  <= '0;
            seoi_reg    <= 1'b1;
        end
        else if (fire)
        begin
            enable_reg  <= enable_next;
            pending_reg <= pending_next;
            inserv_reg  <= inserv_next;
            mask_reg    <= mask_next;
            vector_reg  <= vector_next;
            seoi_reg    <= seoi_next;
        end
    end

endmodule

@@ rtl/interrupt_pending_mask_controller.sv @@
// ----------------------------------------------------------------------------
// interrupt_pending_mask_controller
// Sixteen-channel interrupt controller with enable, pending, in-service and
// mask registers, driven by a stream of bus accesses and channel events.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one item per transfer: a register write, a register
// read, a request on one channel or an acknowledge of one channel. The rsp
// channel returns exactly one result per item, in order, holding the byte read
// (zero for anything but a read) and the set of channels that raise a request.
// An accepted item waits in an input register, is applied to the register
// file from there, and its result is captured in an output register that
// drives rsp. Throughput is one item per cycle while the receiver keeps up;
// the limit is the single register-file update each cycle, since every item
// reads the state the previous one left. When the receiver stalls, the
// result holds in the output register, the next item waits in the input
// register, and req.ready drops only once both are full. Reset clears all
// interrupt registers to zero, sets software end-of-interrupt, and empties
// both pipeline registers.
// ----------------------------------------------------------------------------
module interrupt_pending_mask_controller (
    input  logic         clk,
    input  logic         rst_n,
    ipmc_stream_if.sink   req,
    ipmc_stream_if.source rsp
);
    import ipmc_pkg::*;

    // Input register holding the item waiting to be applied.
    logic  in_valid_reg;
    req_t  in_item_reg;

    // Output register holding the result waiting for the receiver.
    logic  out_valid_reg;
    rsp_t  out_data_reg;

    logic  advance;
    rsp_t  result;

    // The held item is applied whenever the output register is free or is
    // being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);

    // A new item is taken when the input register is empty or moving on.
    assign req.ready = !in_valid_reg || advance;

    ipmc_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers load without reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_item_reg <= req.data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

@@ rtl/ipmc_checker.sv @@
// ----------------------------------------------------------------------------
// ipmc_checker
// Port-level assertions for the interrupt pending/mask controller.
// ----------------------------------------------------------------------------
`include "interrupt_pending_mask_controller_defines.svh"

module ipmc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input ipmc_pkg::rsp_t rsp_data
);
    import ipmc_pkg::*;

    // A stalled result stays offered.
    `IPMC_ASSERT_NXT(a_rsp_valid_hold, rsp_valid && !rsp_ready, rsp_valid)

    // A stalled result keeps its value.
    `IPMC_ASSERT_NXT(a_rsp_data_hold, rsp_valid && !rsp_ready, $stable(rsp_data))

    // The input side only backs up when the output side is stalled.
    `IPMC_ASSERT_IMP(a_req_stall_cause, !req_ready, rsp_valid && !rsp_ready)

    // After every accepted item, a result is offered on rsp.
    `IPMC_ASSERT_IMP(a_rsp_follows, req_valid && req_ready, ##2 rsp_valid)

endmodule

bind interrupt_pending_mask_controller ipmc_checker u_ipmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sixteen-channel interrupt pending/mask
// controller. Bus accesses and channel events are streamed into the req
// channel, and an in-bench model of the enable, pending, in-service and mask
// registers predicts each result, which is checked field by field on rsp.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ipmc_pkg::*;

    // Offsets that decode to nothing in the block: a timer slot, an even
    // offset, zero and the top of the address range.
    localparam logic [5:0] ADDR_TIMER = 6'h19;
    localparam logic [5:0] ADDR_EVEN  = 6'h08;
    localparam logic [5:0] ADDR_ZERO  = 6'h00;
    localparam logic [5:0] ADDR_TOP   = 6'h3f;

    // Cycles without any transfer on either side before the run is abandoned.
    // The longest correct quiet stretch is the deliberate receiver hold-off.
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_AT     = 400;
    localparam int unsigned HOLD_LEN    = 150;
    localparam int unsigned PHASES      = 5;
    localparam int unsigned PHASE_ITEMS = 245;
    // The pipeline holds only an input and an output register, so a short tail is plenty.
    localparam int unsigned TAIL_CYCLES = 10;

    // One queued bus access or channel event. A set drain flag makes the
    // sender hold back this transfer until every outstanding result is in.
    // The burst flag turns off idling on both sides while this item is sent.
    typedef struct {
        req_t item;
        bit   drain;
        bit   burst;
    } stim_t;

    logic clk;
    logic rst_n;

    ipmc_stream_if #(.payload_t(req_t)) req_ch ();
    ipmc_stream_if #(.payload_t(rsp_t)) rsp_ch ();

    interrupt_pending_mask_controller DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Register image of the controller, updated in transfer order.
    logic [15:0] enable_img;
    logic [15:0] pending_img;
    logic [15:0] inserv_img;
    logic [15:0] mask_img;
    logic [7:0]  vector_img;
    logic        sw_eoi_img;

    stim_t send_q[$];
    rsp_t  expected_rsp_q[$];

    int unsigned items_total;
    int unsigned items_taken;
    int unsigned results_seen;
    int unsigned reads_seen;
    int unsigned raises_seen;
    int unsigned errors;
    int unsigned quiet_cycles;

    bit          req_taken;
    bit          burst_mode;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;

    // The nine decoded register offsets, used to keep most random accesses
    // on live registers.
    logic [5:0] live_regs [9] = '{ADDR_ENABLE_A, ADDR_ENABLE_B, ADDR_PENDING_A,
                                  ADDR_PENDING_B, ADDR_INSERV_A, ADDR_INSERV_B,
                                  ADDR_MASK_A, ADDR_MASK_B, ADDR_VECTOR};

    // ------------------------------------------------------------------------
    // Clock and reset. Reset is released on a falling edge so that the first
    // rising edge out of reset sees stable inputs.
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Register model. Applies one transfer to the image and returns the
    // result the block must give for it.
    // ------------------------------------------------------------------------
    function automatic rsp_t apply_access(input req_t it);
        rsp_t        r;
        logic [15:0] chan_bit;
        logic [15:0] lanes;
        logic [15:0] wide;
        logic [15:0] prev_mask;
        logic [15:0] live;
        logic        upper;

        r        = '0;
        chan_bit = 16'h0001 << it.channel;
        upper    = (it.reg_addr == ADDR_ENABLE_A) || (it.reg_addr == ADDR_PENDING_A) ||
                   (it.reg_addr == ADDR_INSERV_A) || (it.reg_addr == ADDR_MASK_A);
        lanes    = upper ? 16'hff00 : 16'h00ff;
        wide     = {it.write_data, it.write_data} & lanes;

        case (it.cmd)
            CMD_WRITE:
            begin
                case (it.reg_addr)
                    ADDR_ENABLE_A, ADDR_ENABLE_B:
                    begin
                        // Disabling a channel drops its pending request.
                        enable_img  = (enable_img & ~lanes) | wide;
                        pending_img = pending_img & (enable_img | ~lanes);
                    end
                    ADDR_PENDING_A, ADDR_PENDING_B:
                    begin
                        pending_img = pending_img & (wide | ~lanes);
                    end
                    ADDR_INSERV_A, ADDR_INSERV_B:
                    begin
                        // Ending service may let held requests through, and
                        // then the whole set of live requests is raised.
                        inserv_img = inserv_img & (wide | ~lanes);
                        live = enable_img & mask_img & pending_img & ~inserv_img;
                        if ((live & lanes) != 16'h0000)
                        begin
                            r.irq_raise = live;
                        end
                    end
                    ADDR_MASK_A, ADDR_MASK_B:
                    begin
                        prev_mask = mask_img;
                        mask_img  = (mask_img & ~lanes) | wide;
                        if ((mask_img & ~prev_mask & enable_img & pending_img & ~inserv_img
                             & lanes) != 16'h0000)
                        begin
                            r.irq_raise = mask_img & pending_img & ~prev_mask;
                        end
                    end
                    ADDR_VECTOR:
                    begin
                        vector_img = it.write_data;
                        sw_eoi_img = it.write_data[VEC_SEOI_BIT];
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_READ:
            begin
                case (it.reg_addr)
                    ADDR_ENABLE_A:  r.read_data = enable_img[15:8];
                    ADDR_ENABLE_B:  r.read_data = enable_img[7:0];
                    ADDR_PENDING_A: r.read_data = pending_img[15:8];
                    ADDR_PENDING_B: r.read_data = pending_img[7:0];
                    ADDR_INSERV_A:  r.read_data = inserv_img[15:8];
                    ADDR_INSERV_B:  r.read_data = inserv_img[7:0];
                    ADDR_MASK_A:    r.read_data = mask_img[15:8];
                    ADDR_MASK_B:    r.read_data = mask_img[7:0];
                    ADDR_VECTOR:    r.read_data = vector_img;
                    default:        r.read_data = 8'h00;
                endcase
            end
            CMD_REQUEST:
            begin
                // A disabled or already pending channel ignores the request.
                if ((enable_img & chan_bit) != 16'h0000 && (pending_img & chan_bit) == 16'h0000)
                begin
                    pending_img = pending_img | chan_bit;
                    if ((mask_img & chan_bit) != 16'h0000 &&
                        !(sw_eoi_img && (inserv_img & chan_bit) != 16'h0000))
                    begin
                        r.irq_raise = chan_bit;
                    end
                end
            end
            default:
            begin
                // Acknowledge: the request is taken, and under software
                // end-of-interrupt the channel enters service.
                pending_img = pending_img & ~chan_bit;
                if (sw_eoi_img)
                begin
                    inserv_img = inserv_img | chan_bit;
                end
            end
        endcase
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            return 0;
        end
        if (roll < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    task automatic queue_item(input cmd_t cmd, input logic [5:0] addr,
                              input logic [7:0] data, input logic [3:0] chan,
                              input bit drain, input bit burst);
        stim_t s;

        s.item.cmd        = cmd;
        s.item.reg_addr   = addr;
        s.item.write_data = data;
        s.item.channel    = chan;
        s.drain           = drain;
        s.burst           = burst;
        send_q.push_back(s);
        items_total++;
    endtask

    // A random access, weighted toward live registers and toward set bits
    // on writes, so that channels stay enabled and unmasked long enough for
    // requests, acknowledges and end-of-service to interact.
    task automatic queue_random(input bit burst);
        int unsigned roll;
        cmd_t        cmd;
        logic [5:0]  addr;
        logic [7:0]  data;

        roll = $urandom_range(0, 99);
        if (roll < 32)
        begin
            cmd = CMD_WRITE;
        end
        else if (roll < 50)
        begin
            cmd = CMD_READ;
        end
        else if (roll < 82)
        begin
            cmd = CMD_REQUEST;
        end
        else
        begin
            cmd = CMD_ACK;
        end

        if ($urandom_range(0, 99) < 88)
        begin
            addr = live_regs[$urandom_range(0, 8)];
        end
        else
        begin
            addr = 6'($urandom_range(0, 63));
        end

        if (cmd == CMD_WRITE && addr != ADDR_VECTOR && $urandom_range(0, 3) != 0)
        begin
            data = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
        end
        else
        begin
            data = 8'($urandom_range(0, 255));
        end

        queue_item(cmd, addr, data, 4'($urandom_range(0, 15)), 1'b0, burst);
    endtask

    // ------------------------------------------------------------------------
    // Request side driver. Inputs change on the falling edge. A transfer that
    // completed on the previous rising edge frees the channel for the next
    // queued item, so valid stays high across back-to-back transfers.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic busy;

        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            busy      = req_ch.valid && !req_taken;
            req_taken = 1'b0;
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (send_q.size() > 0 &&
                         !(send_q[0].drain && expected_rsp_q.size() != 0))
                begin
                    req_ch.data  <= send_q[0].item;
                    req_ch.valid <= 1'b1;
                    burst_mode    = send_q[0].burst;
                    send_q.pop_front();
                    send_gap = burst_mode ? 0 : pick_gap();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side ready. Random stalls, none during burst stretches, and one
    // long hold-off partway through so that both pipeline stages fill and
    // the block has to push back on the request side.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!hold_done && items_taken >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!burst_mode && $urandom_range(0, 99) < 20)
        begin
            stall_left = pick_gap();
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitors, sampled on the rising edge. Each accepted request is run
    // through the register model at once, which keeps the model in step with
    // the block's own order of updates.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;

        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsp_q.push_back(apply_access(req_ch.data));
                req_taken = 1'b1;
                items_taken++;
            end

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.data;
                results_seen++;
                if (expected_rsp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing outstanding: read_data %h irq_raise %h",
                             $realtime, got.read_data, got.irq_raise);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        errors++;
                        $display("%0t: read_data mismatch: expected %h actual %h",
                                 $realtime, want.read_data, got.read_data);
                    end
                    if (got.irq_raise !== want.irq_raise)
                    begin
                        errors++;
                        $display("%0t: irq_raise mismatch: expected %h actual %h",
                                 $realtime, want.irq_raise, got.irq_raise);
                    end
                    if (want.read_data != 8'h00)
                    begin
                        reads_seen++;
                    end
                    if (want.irq_raise != 16'h0000)
                    begin
                        raises_seen++;
                    end
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
                    $display("testbench NOT OK");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;

        enable_img  = '0;
        pending_img = '0;
        inserv_img  = '0;
        mask_img    = '0;
        vector_img  = '0;
        sw_eoi_img  = 1'b1;

        items_total  = 0;
        items_taken  = 0;
        results_seen = 0;
        reads_seen   = 0;
        raises_seen  = 0;
        errors       = 0;
        quiet_cycles = 0;
        req_taken    = 1'b0;
        burst_mode   = 1'b0;
        send_gap     = 0;
        stall_left   = 0;
        hold_left    = 0;
        hold_done    = 1'b0;

        // Directed part. Reset values and dead offsets read back first.
        queue_item(CMD_READ,  ADDR_VECTOR,   8'h00, 4'd0,  1'b0, 1'b0);
        queue_item(CMD_READ,  ADDR_ZERO,     8'h00, 4'd0,  1'b0, 1'b0);
        queue_item(CMD_READ,  ADDR_TOP,      8'hff, 4'd15, 1'b0, 1'b0);
        // Enable and unmask everything; no request is pending yet.
        queue_item(CMD_WRITE, ADDR_ENABLE_A, 8'hff, 4'd0,  1'b0, 1'b0);
        queue_item(CMD_WRITE, ADDR_ENABLE_B, 8'hff, 4'd0,  1'b0, 1'b0);
        queue_item(CMD_WRITE, ADDR_MASK_A,   8'hff, 4'd0,  1'b0, 1'b0);
        queue_item(CMD_WRITE, ADDR_MASK_B,   8'hff, 4'd0,  1'b0, 1'b0);
        // Requests on the lowest and highest channel raise at once; a second
        // request on a pending channel is dropped.
        queue_item(CMD_REQUEST, ADDR_ZERO,   8'h00, 4'd0,  1'b0, 1'b0);
        queue_item(CMD_REQUEST, ADDR_TOP,    8'hff, 4'd15, 1'b0, 1'b0);
        queue_item(CMD_REQUEST, ADDR_ZERO,   8'h00, 4'd0,  1'b0, 1'b0);
        // Acknowledge puts the channel in service, so a new request is held.
        queue_item(CMD_ACK,     ADDR_ZERO,   8'h00, 4'd0,  1'b0, 1'b0);
        queue_item(CMD_REQUEST, ADDR_ZERO,   8'h00, 4'd0,  1'b0, 1'b0);
        queue_item(CMD_READ,    ADDR_INSERV_B, 8'h00, 4'd0, 1'b0, 1'b0);
        // Ending service releases the held request.
        queue_item(CMD_WRITE,   ADDR_INSERV_B, 8'h00, 4'd0, 1'b0, 1'b0);
        // A masked request waits and is raised when the mask opens again.
        queue_item(CMD_WRITE,   ADDR_MASK_B,   8'h00, 4'd0, 1'b0, 1'b0);
        queue_item(CMD_REQUEST, ADDR_ZERO,     8'h00, 4'd3, 1'b0, 1'b0);
        queue_item(CMD_WRITE,   ADDR_MASK_B,   8'hff, 4'd0, 1'b0, 1'b0);
        // Disabling the low byte drops its pending requests; requests on a
        // disabled channel are ignored. Pending writes only clear.
        queue_item(CMD_WRITE,   ADDR_ENABLE_B, 8'h00, 4'd0, 1'b0, 1'b0);
        queue_item(CMD_REQUEST, ADDR_ZERO,     8'h00, 4'd1, 1'b0, 1'b0);
        queue_item(CMD_READ,    ADDR_PENDING_A, 8'h00, 4'd0, 1'b0, 1'b0);
        queue_item(CMD_WRITE,   ADDR_PENDING_A, 8'h00, 4'd0, 1'b0, 1'b0);
        // Writes to dead offsets change nothing; the vector write turns off
        // software end-of-interrupt and reads back.
        queue_item(CMD_WRITE,   ADDR_TIMER,    8'hff, 4'd0, 1'b0, 1'b0);
        queue_item(CMD_WRITE,   ADDR_EVEN,     8'hff, 4'd0, 1'b0, 1'b0);
        queue_item(CMD_WRITE,   ADDR_VECTOR,   8'hf7, 4'd0, 1'b0, 1'b0);
        queue_item(CMD_ACK,     ADDR_TOP,      8'h00, 4'd15, 1'b0, 1'b0);
        queue_item(CMD_READ,    ADDR_VECTOR,   8'h00, 4'd0, 1'b0, 1'b0);

        // Random phases. Each opens after the pipeline has drained, with all
        // channels enabled and unmasked and software end-of-interrupt chosen
        // per phase. The second phase runs without idling on either side.
        for (int p = 0; p < PHASES; p++)
        begin
            bit burst;

            burst = (p == 1);
            queue_item(CMD_WRITE, ADDR_ENABLE_A, 8'hff, 4'd0, 1'b1, burst);
            queue_item(CMD_WRITE, ADDR_ENABLE_B, 8'hff, 4'd0, 1'b0, burst);
            queue_item(CMD_WRITE, ADDR_MASK_A,   8'hff, 4'd0, 1'b0, burst);
            queue_item(CMD_WRITE, ADDR_MASK_B,   8'hff, 4'd0, 1'b0, burst);
            queue_item(CMD_WRITE, ADDR_VECTOR,
                       (p % 2 == 0) ? 8'h48 : 8'h40, 4'd0, 1'b0, burst);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                queue_random(burst);
            end
        end

        while (items_taken < items_total || expected_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d accesses and channel events through %0d results, %0d of them",
                 items_taken, results_seen, raises_seen);
        $display("raising requests and %0d returning nonzero register data.", reads_seen);
        if (errors == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
